### rtl/scpp_pkg.sv
// ----------------------------------------------------------------------------
// scpp_pkg
// Shared types and constants of the switch configuration packet port.
// ----------------------------------------------------------------------------
package scpp_pkg;

  localparam int unsigned REG_COUNT_DEF     = 64;
  localparam int unsigned MAX_FRAME_TOKENS  = 10;
  localparam int unsigned READ_FRAME_TOKENS = 6;
  localparam int unsigned TOK_W             = 9;
  localparam int unsigned CNT_W             = $clog2(MAX_FRAME_TOKENS + 1);
  localparam int unsigned STEP_W            = 3;

  // Position of the closing END beat in each kind of response.
  localparam logic [STEP_W-1:0] READ_LAST_STEP  = STEP_W'(5);
  localparam logic [STEP_W-1:0] SHORT_LAST_STEP = STEP_W'(1);

  typedef enum logic [2:0] {
    CFG_END       = 3'd0,
    CFG_PAUSE     = 3'd1,
    CFG_ACK       = 3'd2,
    CFG_NACK      = 3'd3,
    CFG_WRITE_REQ = 3'd4,
    CFG_READ_REQ  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] code_end;
    logic [7:0] code_pause;
    logic [7:0] code_ack;
    logic [7:0] code_nack;
    logic [7:0] code_write_req;
    logic [7:0] code_read_req;
  } cfg_t;

  // Decoded request of one valid frame, handed out for one cycle.
  typedef struct packed {
    logic        valid;
    logic        is_write;
    logic        ack;
    logic [15:0] idx;
    logic [15:0] node;
    logic [7:0]  chan;
    logic [31:0] data;
  } req_t;

endpackage

### rtl/scpp_frame.sv
// ----------------------------------------------------------------------------
// scpp_frame
// Token buffer, token count and junk flag; parses the frame on END.
// ----------------------------------------------------------------------------
module scpp_frame #(
  parameter int unsigned REG_COUNT = scpp_pkg::REG_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  scpp_pkg::cfg_t cfg_i,
  input  logic          tok_acc_i,
  input  logic          is_control_i,
  input  logic [7:0]    token_value_i,
  output logic          is_end_o,
  output scpp_pkg::req_t req_o
);
  import scpp_pkg::*;

  logic [TOK_W-1:0] buf_q [MAX_FRAME_TOKENS];
  logic [CNT_W-1:0] count_q, count_d;
  logic             junk_q, junk_d;
  logic             is_pause;
  logic             store;
  logic             hdr_read, hdr_write;
  logic             ctl_read, ctl_write;
  logic             frame_ok;

  assign is_end_o = is_control_i && (token_value_i == cfg_i.code_end);
  assign is_pause = is_control_i && (token_value_i == cfg_i.code_pause);

  always_comb begin
    count_d = count_q;
    junk_d  = junk_q;
    store   = 1'b0;
    if (tok_acc_i) begin
      if (is_end_o) begin
        count_d = '0;
        junk_d  = 1'b0;
      end else if (is_pause || junk_q) begin
        count_d = count_q;
      end else if (count_q >= CNT_W'(MAX_FRAME_TOKENS)) begin
        junk_d = 1'b1;
      end else begin
        store   = 1'b1;
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      junk_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      junk_q  <= junk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_FRAME_TOKENS; i++) begin
      if (store && (count_q == CNT_W'(i))) begin
        buf_q[i] <= {is_control_i, token_value_i};
      end
    end
  end

  // A header matching both request codes is taken as a read.
  assign hdr_read  = buf_q[0][8] && (buf_q[0][7:0] == cfg_i.code_read_req);
  assign hdr_write = buf_q[0][8] && !hdr_read &&
                     (buf_q[0][7:0] == cfg_i.code_write_req);

  always_comb begin
    ctl_read  = 1'b0;
    ctl_write = 1'b0;
    for (int i = 1; i < MAX_FRAME_TOKENS; i++) begin
      if (i < READ_FRAME_TOKENS) begin
        ctl_read = ctl_read | buf_q[i][8];
      end
      ctl_write = ctl_write | buf_q[i][8];
    end
  end

  assign frame_ok = !junk_q &&
                    ((hdr_read && (count_q == CNT_W'(READ_FRAME_TOKENS)) && !ctl_read) ||
                     (hdr_write && (count_q == CNT_W'(MAX_FRAME_TOKENS)) && !ctl_write));

  always_comb begin
    req_o.valid    = tok_acc_i && is_end_o && frame_ok;
    req_o.is_write = hdr_write;
    req_o.node     = {buf_q[1][7:0], buf_q[2][7:0]};
    req_o.chan     = buf_q[3][7:0];
    req_o.idx      = {buf_q[4][7:0], buf_q[5][7:0]};
    req_o.data     = {buf_q[6][7:0], buf_q[7][7:0], buf_q[8][7:0], buf_q[9][7:0]};
    req_o.ack      = {1'b0, req_o.idx} < 17'(REG_COUNT);
  end

endmodule

### rtl/scpp_regfile.sv
// ----------------------------------------------------------------------------
// scpp_regfile
// Register store in a synchronous memory, with a clearing pass after reset.
// ----------------------------------------------------------------------------
module scpp_regfile #(
  parameter int unsigned REG_COUNT = scpp_pkg::REG_COUNT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  scpp_pkg::req_t req_i,
  output logic [31:0]    rdata_o,
  output logic           clearing_o
);
  import scpp_pkg::*;

  localparam int unsigned AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [31:0]   mem [REG_COUNT];
  logic [31:0]   rdata_q;
  logic [AW-1:0] clr_q, clr_d;
  logic          clearing_q, clearing_d;
  logic [AW-1:0] addr;
  logic          do_write, do_read;

  assign addr     = req_i.idx[AW-1:0];
  assign do_write = req_i.valid && req_i.ack && req_i.is_write;
  assign do_read  = req_i.valid && req_i.ack && !req_i.is_write;

  always_comb begin
    clr_d      = clr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      if (clr_q == AW'(REG_COUNT - 1)) begin
        clearing_d = 1'b0;
      end else begin
        clr_d = clr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_q      <= clr_d;
      clearing_q <= clearing_d;
    end
  end

  // No request can arrive while clearing, since input is held off then.
  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_q] <= '0;
    end else if (do_write) begin
      mem[addr] <= req_i.data;
    end
    if (do_read) begin
      rdata_q <= mem[addr];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clearing_q;

endmodule

### rtl/scpp_resp.sv
// ----------------------------------------------------------------------------
// scpp_resp
// Response sequencer: holds one request and emits its beats in order.
// ----------------------------------------------------------------------------
module scpp_resp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  scpp_pkg::cfg_t cfg_i,
  input  scpp_pkg::req_t req_i,
  input  logic [31:0]    rdata_i,
  input  logic           out_stall_i,
  output logic           hold_o,
  output logic           out_valid_o,
  output logic           out_is_control_o,
  output logic [7:0]     out_value_o,
  output logic [15:0]    reply_node_o,
  output logic [7:0]     reply_channel_o,
  output logic           last_o
);
  import scpp_pkg::*;

  logic              busy_q, busy_d;
  logic              rd_pend_q;
  logic              is_read_q, ack_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] last_step;
  logic [15:0]       node_q;
  logic [7:0]        chan_q;
  logic [31:0]       data_q;
  logic              beat_done;

  assign last_step = is_read_q ? READ_LAST_STEP : SHORT_LAST_STEP;
  assign last_o    = (step_q == last_step);
  assign beat_done = busy_q && !out_stall_i;

  // A new request may enter in the cycle that the last beat is taken.
  assign hold_o = busy_q && !(beat_done && last_o);

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (beat_done) begin
      if (last_o) begin
        busy_d = 1'b0;
        step_d = '0;
      end else begin
        step_d = step_q + STEP_W'(1);
      end
    end
    if (req_i.valid) begin
      busy_d = 1'b1;
      step_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      step_q    <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      step_q    <= step_d;
      rd_pend_q <= req_i.valid && req_i.ack && !req_i.is_write;
    end
  end

  // Read data arrives in the cycle after the request, before the first data beat.
  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      is_read_q <= req_i.ack && !req_i.is_write;
      ack_q     <= req_i.ack;
      node_q    <= req_i.node;
      chan_q    <= req_i.chan;
    end
    if (rd_pend_q) begin
      data_q <= rdata_i;
    end
  end

  always_comb begin
    out_is_control_o = 1'b0;
    out_value_o      = data_q[7:0];
    if (step_q == '0) begin
      out_is_control_o = 1'b1;
      out_value_o      = ack_q ? cfg_i.code_ack : cfg_i.code_nack;
    end else if (last_o) begin
      out_is_control_o = 1'b1;
      out_value_o      = cfg_i.code_end;
    end else begin
      case (step_q)
        STEP_W'(1): out_value_o = data_q[31:24];
        STEP_W'(2): out_value_o = data_q[23:16];
        STEP_W'(3): out_value_o = data_q[15:8];
        default:    out_value_o = data_q[7:0];
      endcase
    end
  end

  assign out_valid_o     = busy_q;
  assign reply_node_o    = node_q;
  assign reply_channel_o = chan_q;

endmodule

### rtl/switch_config_packet_port_top.sv
// ----------------------------------------------------------------------------
// switch_config_packet_port_top
// Configuration port of a link switch: buffers request frames, reads or
// writes the register store and answers with ACK/NACK, read data and END.
// ----------------------------------------------------------------------------
// Tokens are taken one per cycle while in_stall_o is low. An END that
// closes a valid frame reads or writes the register memory in that cycle
// and starts a response of six beats (read) or two beats (write, refused
// access); other tokens keep flowing meanwhile, but a further END waits
// until the last beat of the running response is taken, since the response
// sequencer holds one request. Read data comes from the memory's registered
// port in the cycle after the END and is in place before the first data
// beat. After reset a clearing pass zeroes the register store, one word per
// cycle; input is held off during it while configuration writes are taken.
module switch_config_packet_port_top #(
  parameter int unsigned REG_COUNT = scpp_pkg::REG_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        is_control_i,
  input  logic [7:0]  token_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_is_control_o,
  output logic [7:0]  out_value_o,
  output logic [15:0] reply_node_o,
  output logic [7:0]  reply_channel_o,
  output logic        last_o
);
  import scpp_pkg::*;

  cfg_t        cfg_q;
  req_t        req;
  logic        is_end;
  logic        hold;
  logic        clearing;
  logic        tok_acc;
  logic [31:0] rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_end       <= 8'd1;
      cfg_q.code_pause     <= 8'd2;
      cfg_q.code_ack       <= 8'd3;
      cfg_q.code_nack      <= 8'd4;
      cfg_q.code_write_req <= 8'd192;
      cfg_q.code_read_req  <= 8'd193;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_END:       cfg_q.code_end       <= cfg_data_i;
        CFG_PAUSE:     cfg_q.code_pause     <= cfg_data_i;
        CFG_ACK:       cfg_q.code_ack       <= cfg_data_i;
        CFG_NACK:      cfg_q.code_nack      <= cfg_data_i;
        CFG_WRITE_REQ: cfg_q.code_write_req <= cfg_data_i;
        CFG_READ_REQ:  cfg_q.code_read_req  <= cfg_data_i;
        default:       cfg_q                <= cfg_q;
      endcase
    end
  end

  assign in_stall_o = clearing || (is_end && hold);
  assign tok_acc    = in_valid_i && !in_stall_o;

  scpp_frame #(
    .REG_COUNT(REG_COUNT)
  ) u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .tok_acc_i     (tok_acc),
    .is_control_i  (is_control_i),
    .token_value_i (token_value_i),
    .is_end_o      (is_end),
    .req_o         (req)
  );

  scpp_regfile #(
    .REG_COUNT(REG_COUNT)
  ) u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rdata_o    (rdata),
    .clearing_o (clearing)
  );

  scpp_resp u_resp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .req_i            (req),
    .rdata_i          (rdata),
    .out_stall_i      (out_stall_i),
    .hold_o           (hold),
    .out_valid_o      (out_valid_o),
    .out_is_control_o (out_is_control_o),
    .out_value_o      (out_value_o),
    .reply_node_o     (reply_node_o),
    .reply_channel_o  (reply_channel_o),
    .last_o           (last_o)
  );

endmodule

### rtl/scpp_checker.sv
// ----------------------------------------------------------------------------
// scpp_checker
// Port-level checks of the configuration packet port, bound to the top.
// ----------------------------------------------------------------------------
module scpp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        is_control_i,
  input logic [7:0]  token_value_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        out_is_control_o,
  input logic [7:0]  out_value_o,
  input logic [15:0] reply_node_o,
  input logic [7:0]  reply_channel_o,
  input logic        last_o
);

  // A stalled input beat stays offered and keeps its contents.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(is_control_i) &&
    $stable(token_value_i))
    else $error("stalled input beat changed");

  // A stalled beat keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_value_o) &&
    $stable(out_is_control_o) && $stable(last_o))
    else $error("stalled response beat changed");

  // The closing beat of a response is always a control token.
  a_last_ctl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> out_is_control_o)
    else $error("last beat is not a control token");

  // A response runs without gaps and keeps its return address.
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
    out_valid_o && $stable(reply_node_o) && $stable(reply_channel_o))
    else $error("response broken or return address changed");

  // A new response opens with ACK or NACK, never with a data beat.
  a_open_ctl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_o |=> !(out_valid_o && !out_is_control_o))
    else $error("response opened with a data beat");

endmodule

bind switch_config_packet_port_top scpp_checker u_scpp_checker (.*);
